[rtl/core/uv_sphere_vertex_generator_assert.svh]
// Assertion macros for the sphere vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define UVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UVS_ASSERT(label, prop, msg)
`define UVS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/uvs_pkg.sv]
package uvs_pkg;

  localparam int SW        = 11;  // slice count width
  localparam int RW        = 12;  // partial remainder width
  localparam int QW        = 33;  // integer bit plus 32 fraction bits
  localparam int DIV_STEPS = 32;
  localparam int TAP_STEP  = 13;  // remainder after 14 fraction bits
  localparam int NLANE     = 3;
  localparam int LANE_RS   = 0;   // ring index over slices
  localparam int LANE_SS   = 1;   // slice index over slices
  localparam int LANE_RR   = 2;   // ring index over rings
  localparam int CW        = 34;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [3:0] REG_RADIUS = 4'd0;
  localparam logic [3:0] REG_SLICES = 4'd1;

  localparam logic [14:0] ONE_Q14   = 15'd16384;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [CW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  typedef struct packed {
    logic [9:0]  ring_index;
    logic [10:0] slice_index;
  } in_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic               index_error;
  } out_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] quo;
    logic [RW-1:0] rem_tap;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NLANE-1:0] lane;
    logic                  err;
  } div_t;

  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
  } rot_t;

  typedef struct packed {
    rot_t  [1:0] rot;   // 0: ring angle, 1: slice angle
    quad_t [1:0] quad;
    logic [14:0] tex_u;
    logic [14:0] tex_v;
    logic        err;
  } cord_t;

  // First step of the long division: integer quotient bit and remainder.
  function automatic div_lane_t div_init(input logic [SW-1:0] n, input logic [SW-1:0] d);
    div_lane_t l;
    logic ge;
    ge = (n >= d);
    l.rem = ge ? RW'(n - d) : RW'(n);
    l.quo = QW'(ge);
    l.rem_tap = '0;
    return l;
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [18:0] v);
    if (v > 19'sd16384) begin
      return 16'sd16384;
    end else if (v < -19'sd16384) begin
      return -16'sd16384;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] round_q30(input cw_t v);
    logic signed [CW:0] s;
    logic signed [CW:0] t;
    s = (CW+1)'(v) + 35'sd32768;
    t = s >>> 16;
    return clamp_unit(t[18:0]);
  endfunction

  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    logic signed [32:0] s;
    logic signed [32:0] t;
    p = a * b;
    s = 33'(p) + 33'sd8192;
    t = s >>> 14;
    return clamp_unit(t[18:0]);
  endfunction

endpackage

[rtl/core/uvs_div_cell.sv]
module uvs_div_cell import uvs_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NLANE-1:0][SW-1:0]   dvsr,
  input  div_t                       d_in,
  output div_t                       d_out
);

  div_t nxt;

  always_comb begin
    logic [RW:0] two;
    logic        ge;
    logic [RW:0] rn;
    nxt = d_in;
    for (int l = 0; l < NLANE; l++) begin
      two = {d_in.lane[l].rem, 1'b0};
      ge  = (two >= (RW+1)'(dvsr[l]));
      rn  = ge ? two - (RW+1)'(dvsr[l]) : two;
      nxt.lane[l].rem = rn[RW-1:0];
      nxt.lane[l].quo = {d_in.lane[l].quo[QW-2:0], ge};
      if (STEP == TAP_STEP) begin
        nxt.lane[l].rem_tap = rn[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

[rtl/core/uvs_cordic_cell.sv]
module uvs_cordic_cell import uvs_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t d_in,
  output cord_t d_out
);

  cord_t nxt;

  always_comb begin
    cw_t x;
    cw_t y;
    cw_t z;
    cw_t dx;
    cw_t dy;
    nxt = d_in;
    for (int a = 0; a < 2; a++) begin
      x  = d_in.rot[a].x;
      y  = d_in.rot[a].y;
      z  = d_in.rot[a].z;
      dx = y >>> STEP;
      dy = x >>> STEP;
      if (!z[CW-1]) begin
        nxt.rot[a].x = x - dx;
        nxt.rot[a].y = y + dy;
        nxt.rot[a].z = z - ATAN_Q30[STEP];
      end else begin
        nxt.rot[a].x = x + dx;
        nxt.rot[a].y = y - dy;
        nxt.rot[a].z = z + ATAN_Q30[STEP];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

[rtl/core/uv_sphere_vertex_generator.sv]
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | in_data (ring_index, slice_index)
// out      | output    | out_valid / out_stall| out_data (vertex attributes)
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One grid point per cycle while the skid stage is empty and the pipeline is not stalled.
// The latency is set by the 32-cell restoring divider chain and the CORDIC cell chain.
// rst is synchronous: clears valid bits, skid and registers (radius 1.0, 16 slices).
// A stalled output parks one result in a skid stage; in_stall rises only while it is full.
`include "uv_sphere_vertex_generator_assert.svh"

module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int MAX_SLICES    = 1024,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LAT = DIV_STEPS + CORDIC_STAGES + 6;

  logic [15:0]   radius;
  logic [SW-1:0] slice_count;
  logic [SW-1:0] s_eff;
  logic [SW-1:0] r_eff;
  logic [SW-1:0] h_s;
  logic [SW-1:0] h_r;
  logic          en;
  logic [LAT-1:0] vl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 16'd256;
      slice_count <= SW'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS: radius      <= cfg_data;
        REG_SLICES: slice_count <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slice_count < SW'(2)) begin
      s_eff = SW'(2);
    end else if (13'(slice_count) > 13'(MAX_SLICES)) begin
      s_eff = SW'(MAX_SLICES);
    end else begin
      s_eff = slice_count;
    end
    r_eff = s_eff >> 1;
    h_s   = s_eff >> 1;
    h_r   = r_eff >> 1;
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (en) begin
      vl <= {vl[LAT-2:0], in_valid};
    end
  end

  // divider chain
  div_t dv [DIV_STEPS+1];
  logic [NLANE-1:0][SW-1:0] dvsr;

  assign dvsr[LANE_RS] = s_eff;
  assign dvsr[LANE_SS] = s_eff;
  assign dvsr[LANE_RR] = r_eff;

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].lane[LANE_RS] <= div_init(SW'(in_data.ring_index), s_eff);
      dv[0].lane[LANE_SS] <= div_init(in_data.slice_index, s_eff);
      dv[0].lane[LANE_RR] <= div_init(SW'(in_data.ring_index), r_eff);
      dv[0].err <= (SW'(in_data.ring_index) > r_eff) || (in_data.slice_index > s_eff);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    uvs_div_cell #(.STEP(k)) u_cell (
      .clk  (clk),
      .en   (en),
      .dvsr (dvsr),
      .d_in (dv[k]),
      .d_out(dv[k+1])
    );
  end

  // round quotients into phases and texture coordinates
  logic [1:0][31:0] phase;
  logic [14:0]      p_tex_u;
  logic [14:0]      p_tex_v;
  logic             p_err;

  always_ff @(posedge clk) begin
    div_t f;
    logic rnd;
    logic [14:0] q;
    f = dv[DIV_STEPS];
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        rnd = ((RW+1)'(f.lane[a].rem) + (RW+1)'(h_s)) >= (RW+1)'(s_eff);
        phase[a] <= f.lane[a].quo[31:0] + 32'(rnd);
      end
      rnd = ((RW+1)'(f.lane[LANE_SS].rem_tap) + (RW+1)'(h_s)) >= (RW+1)'(s_eff);
      p_tex_u <= f.lane[LANE_SS].quo[QW-1:QW-15] + 15'(rnd);
      rnd = ((RW+1)'(f.lane[LANE_RR].rem_tap) + (RW+1)'(h_r)) >= (RW+1)'(r_eff);
      q = f.lane[LANE_RR].quo[QW-1:QW-15] + 15'(rnd);
      p_tex_v <= ONE_Q14 - q;
      p_err   <= f.err;
    end
  end

  // quarter-turn fraction to radians, then the CORDIC chain
  cord_t cv [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    logic [60:0] prod;
    logic [60:0] zr;
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        prod = 61'(phase[a][29:0]) * 61'(HALF_PI_Q30);
        zr   = (prod + 61'(1 << 29)) >> 30;
        cv[0].rot[a].x <= INV_GAIN_Q30;
        cv[0].rot[a].y <= '0;
        cv[0].rot[a].z <= signed'(CW'(zr[30:0]));
        cv[0].quad[a]  <= quad_t'(phase[a][31:30]);
      end
      cv[0].tex_u <= p_tex_u;
      cv[0].tex_v <= p_tex_v;
      cv[0].err   <= p_err;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    uvs_cordic_cell #(.STEP(k)) u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (cv[k]),
      .d_out(cv[k+1])
    );
  end

  // quadrant fold and rounding to Q1.14
  logic signed [1:0][15:0] c14;
  logic signed [1:0][15:0] s14;
  logic [14:0] q_tex_u;
  logic [14:0] q_tex_v;
  logic        q_err;

  always_ff @(posedge clk) begin
    cord_t f;
    cw_t c;
    cw_t s;
    f = cv[CORDIC_STAGES];
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        unique case (f.quad[a])
          QUAD_I:   begin c = f.rot[a].x;  s = f.rot[a].y;  end
          QUAD_II:  begin c = -f.rot[a].y; s = f.rot[a].x;  end
          QUAD_III: begin c = -f.rot[a].x; s = -f.rot[a].y; end
          QUAD_IV:  begin c = f.rot[a].y;  s = -f.rot[a].x; end
          default:  begin c = f.rot[a].x;  s = f.rot[a].y;  end
        endcase
        c14[a] <= round_q30(c);
        s14[a] <= round_q30(s);
      end
      q_tex_u <= f.tex_u;
      q_tex_v <= f.tex_v;
      q_err   <= f.err;
    end
  end

  // normal and tangent
  out_t m;

  always_ff @(posedge clk) begin
    out_t t;
    t             = '0;
    t.normal_x    = mul_q14(s14[0], s14[1]);
    t.normal_y    = c14[0];
    t.normal_z    = mul_q14(s14[0], c14[1]);
    t.tangent_x   = c14[1];
    t.tangent_z   = -s14[1];
    t.tex_u       = q_tex_u;
    t.tex_v       = q_tex_v;
    t.index_error = q_err;
    if (en) begin
      m <= t;
    end
  end

  // position, and zero everything on a bad index
  out_t res;

  function automatic logic signed [23:0] scale(input logic [15:0] r,
                                               input logic signed [15:0] n);
    logic signed [32:0] p;
    logic signed [32:0] t;
    p = signed'(33'(r)) * 33'(n);
    t = (p + 33'sd128) >>> 8;
    return t[23:0];
  endfunction

  always_ff @(posedge clk) begin
    out_t t;
    t       = m;
    t.pos_x = scale(radius, m.normal_x);
    t.pos_y = scale(radius, m.normal_y);
    t.pos_z = scale(radius, m.normal_z);
    if (m.index_error) begin
      t             = '0;
      t.index_error = 1'b1;
    end
    if (en) begin
      res <= t;
    end
  end

  // output register with skid
  logic skid_valid;
  out_t skid_data;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_valid && out_stall) begin
      skid_valid <= vl[LAT-1];
    end else begin
      out_valid <= vl[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_data <= skid_data;
      end
    end else if (out_valid && out_stall) begin
      skid_data <= res;
    end else begin
      out_data <= res;
    end
  end

  `UVS_ASSERT(a_skid_implies_out, !skid_valid || out_valid, "skid holds a beat with no output beat")
  `UVS_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid, "skid did not drain")
  `UVS_ASSERT(a_error_zero, !(out_valid && out_data.index_error) || (out_data.pos_x == 0 && out_data.pos_y == 0 && out_data.pos_z == 0 && out_data.normal_y == 0 && out_data.tex_u == 0 && out_data.tex_v == 0), "error beat carries attributes")
  `UVS_ASSERT(a_normal_range, !out_valid || (out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384), "normal y out of unit range")

endmodule
